### src/ffa_pkg.sv
// package for the first-fit allocator: sizes, status codes, opcodes
// no dependencies
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int unsigned MaxHeldDefault  = 16;
  localparam int unsigned MaxFreeDefault  = 17;
  localparam int unsigned AddrBitsDefault = 16;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned IdBits    = 8;
  localparam int unsigned StatBits  = 3;

  localparam logic [15:0] PoolBaseReset = 16'd1000;
  localparam logic [15:0] PoolLenReset  = 16'd100;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BADREQ  = 3'd4
  } status_e;

  localparam logic APB_REG_BASE = 1'b0;
  localparam logic APB_REG_LEN  = 1'b1;

  // one result transaction
  typedef struct packed {
    status_e         status;
    logic [15:0]     block_base;
    logic [15:0]     block_length;
  } result_t;

endpackage

### src/ffa_regs.sv
// apb configuration registers pool_base and pool_length
// depends on ffa_pkg
`timescale 1ns / 1ps

module ffa_regs
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] pool_base_o,
  output logic [15:0] pool_length_o
);

  logic [15:0] base_q, len_q;
  logic        wr;
  logic        sel_len;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign sel_len = paddr[2];

  // register writes, addresses beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= PoolBaseReset;
      len_q  <= PoolLenReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (sel_len == APB_REG_BASE) base_q <= pwdata[15:0];
      else                         len_q  <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata[15:0] = (sel_len == APB_REG_LEN) ? len_q : base_q;
    end
  end

  assign pool_base_o   = base_q;
  assign pool_length_o = len_q;

endmodule

### src/ffa_engine.sv
// sequencer with one shared compare/add unit scanning the free and held tables
// depends on ffa_pkg
`timescale 1ns / 1ps

module ffa_engine
  import ffa_pkg::*;
#(
  parameter int unsigned MaxHeld  = MaxHeldDefault,
  parameter int unsigned MaxFree  = MaxFreeDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  opcode_e       op_i,
  input  logic [7:0]    id_i,
  input  logic [15:0]   size_i,
  input  logic [15:0]   pool_base_i,
  input  logic [15:0]   pool_length_i,
  output logic          busy_o,
  output logic          done_o,
  output result_t       res_o
);

  localparam int unsigned HW = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;
  localparam int unsigned FW = (MaxFree > 1) ? $clog2(MaxFree) : 1;
  localparam int unsigned AW = AddrBitsDefault;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HELD  = 6'b000010,
    S_FREE  = 6'b000100,
    S_APPLY = 6'b001000,
    S_CLEAR = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] fs_q [MaxFree];
  logic [AW-1:0] fz_q [MaxFree];
  logic [MaxFree-1:0] fv_q;
  logic [7:0]    hid_q [MaxHeld];
  logic [AW-1:0] hs_q [MaxHeld];
  logic [AW-1:0] hz_q [MaxHeld];
  logic [MaxHeld-1:0] hv_q;

  opcode_e     op_q;
  logic [7:0]  id_q;
  logic [15:0] size_q;
  logic [HW:0] hi_q;
  logic [FW:0] fi_q;
  logic        hit_q, slot_ok_q, seg_ok_q, bel_ok_q, abv_ok_q, emp_ok_q;
  logic [HW-1:0] hit_idx_q, slot_q;
  logic [FW-1:0] seg_q, bel_q, abv_q, emp_q;
  logic [AW-1:0] base_q, bsz_q;
  result_t     res_q;

  // shared unit: one compare/add per cycle on the entry under the cursor
  logic [HW-1:0] hidx;
  logic [FW-1:0] fidx;
  logic [AW:0]   f_end, r_end;
  logic          fit, lower;
  assign hidx  = hi_q[HW-1:0];
  assign fidx  = fi_q[FW-1:0];
  assign f_end = {1'b0, fs_q[fidx]} + {1'b0, fz_q[fidx]};
  assign r_end = {1'b0, base_q} + {1'b0, bsz_q};
  assign fit   = {{(AW+1-16){1'b0}}, size_q} <= {1'b0, fz_q[fidx]};
  assign lower = fs_q[fidx] < fs_q[seg_q];

  // held scan outcome at the last record
  logic h_last, f_last, cur_hit, found, no_slot, bad_req, early_exit;
  assign h_last     = (hi_q == (HW+1)'(MaxHeld - 1));
  assign f_last     = (fi_q == (FW+1)'(MaxFree - 1));
  assign cur_hit    = hv_q[hidx] && (hid_q[hidx] == id_q);
  assign found      = hit_q || cur_hit;
  assign no_slot    = !slot_ok_q && hv_q[hidx];
  assign bad_req    = (op_q == OP_ALLOC) && (size_q == '0 || found);
  assign early_exit = bad_req || (op_q == OP_ALLOC && no_slot) ||
                      (op_q == OP_FREE && !found);

  // pool clip for init
  logic [AW-1:0] pbase;
  logic [AW:0]   plen, pend, span;
  assign pbase = AW'(pool_base_i);
  assign span  = {1'b1, {AW{1'b0}}};
  assign pend  = {1'b0, pbase} + (AW+1)'(pool_length_i);
  assign plen  = (pend > span) ? (span - {1'b0, pbase}) : (AW+1)'(pool_length_i);

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (op_i == OP_INIT || op_i == OP_NOP) ? S_CLEAR : S_HELD;
        end
      end
      S_HELD:  if (h_last) state_d = early_exit ? S_DONE : S_FREE;
      S_FREE:  if (f_last) state_d = S_APPLY;
      S_APPLY: state_d = S_DONE;
      S_CLEAR: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fv_q    <= '0;
      hv_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          op_q <= op_i; id_q <= id_i; size_q <= size_i;
          hi_q <= '0; fi_q <= '0;
          hit_q <= 1'b0; slot_ok_q <= 1'b0; seg_ok_q <= 1'b0;
          bel_ok_q <= 1'b0; abv_ok_q <= 1'b0; emp_ok_q <= 1'b0;
          hit_idx_q <= '0; slot_q <= '0; seg_q <= '0;
          bel_q <= '0; abv_q <= '0; emp_q <= '0;
        end
        S_HELD: begin
          // held scan: id lookup and lowest free slot
          if (cur_hit && !hit_q) begin
            hit_q <= 1'b1; hit_idx_q <= hidx;
            base_q <= hs_q[hidx]; bsz_q <= hz_q[hidx];
          end
          if (!hv_q[hidx] && !slot_ok_q) begin
            slot_ok_q <= 1'b1; slot_q <= hidx;
          end
          hi_q <= hi_q + 1'b1;
          if (h_last) begin
            if (bad_req) begin
              res_q <= '{ST_BADREQ, 16'd0, 16'd0};
            end else if (op_q == OP_ALLOC && no_slot) begin
              res_q <= '{ST_FULL, 16'd0, 16'd0};
            end else if (op_q == OP_FREE && !found) begin
              res_q <= '{ST_UNKNOWN, 16'd0, 16'd0};
            end
          end
        end
        S_FREE: begin
          if (fv_q[fidx]) begin
            if (op_q == OP_ALLOC && fit && (!seg_ok_q || lower)) begin
              seg_ok_q <= 1'b1; seg_q <= fidx;
            end
            if (op_q == OP_FREE && f_end == r_end - (AW+1)'(bsz_q)) begin
              bel_ok_q <= 1'b1; bel_q <= fidx;
            end
            if (op_q == OP_FREE && {1'b0, fs_q[fidx]} == r_end) begin
              abv_ok_q <= 1'b1; abv_q <= fidx;
            end
          end else if (!emp_ok_q) begin
            emp_ok_q <= 1'b1; emp_q <= fidx;
          end
          fi_q <= fi_q + 1'b1;
        end
        S_APPLY: begin
          if (op_q == OP_ALLOC) begin
            if (!seg_ok_q) begin
              res_q <= '{ST_NOFIT, 16'd0, 16'd0};
            end else begin
              hv_q[slot_q] <= 1'b1; hid_q[slot_q] <= id_q;
              hs_q[slot_q] <= fs_q[seg_q]; hz_q[slot_q] <= AW'(size_q);
              if (fz_q[seg_q] == AW'(size_q)) begin
                fv_q[seg_q] <= 1'b0; fs_q[seg_q] <= '0; fz_q[seg_q] <= '0;
              end else begin
                fs_q[seg_q] <= fs_q[seg_q] + AW'(size_q);
                fz_q[seg_q] <= fz_q[seg_q] - AW'(size_q);
              end
              res_q <= '{ST_OK, 16'(fs_q[seg_q]), size_q};
            end
          end else begin
            if (!bel_ok_q && !abv_ok_q && !emp_ok_q) begin
              res_q <= '{ST_FULL, 16'd0, 16'd0};
            end else begin
              priority if (bel_ok_q && abv_ok_q) begin
                fz_q[bel_q] <= fz_q[bel_q] + bsz_q + fz_q[abv_q];
                fv_q[abv_q] <= 1'b0; fs_q[abv_q] <= '0; fz_q[abv_q] <= '0;
              end else if (bel_ok_q) begin
                fz_q[bel_q] <= fz_q[bel_q] + bsz_q;
              end else if (abv_ok_q) begin
                fs_q[abv_q] <= base_q; fz_q[abv_q] <= fz_q[abv_q] + bsz_q;
              end else begin
                fv_q[emp_q] <= 1'b1; fs_q[emp_q] <= base_q; fz_q[emp_q] <= bsz_q;
              end
              hv_q[hit_idx_q] <= 1'b0; hid_q[hit_idx_q] <= '0;
              hs_q[hit_idx_q] <= '0; hz_q[hit_idx_q] <= '0;
              res_q <= '{ST_OK, 16'(base_q), 16'(bsz_q)};
            end
          end
        end
        S_CLEAR: begin
          if (op_q == OP_INIT) begin
            // clear both tables, the pool becomes segment 0 when not empty
            fv_q <= {{(MaxFree-1){1'b0}}, (plen != '0)};
            hv_q <= '0;
            for (int i = 0; i < int'(MaxFree); i++) begin
              if (i == 0 && plen != '0) begin
                fs_q[i] <= pbase; fz_q[i] <= AW'(plen);
              end else begin
                fs_q[i] <= '0; fz_q[i] <= '0;
              end
            end
            for (int i = 0; i < int'(MaxHeld); i++) begin
              hid_q[i] <= '0; hs_q[i] <= '0; hz_q[i] <= '0;
            end
            res_q <= '{ST_OK, 16'(pbase), 16'(plen)};
          end else begin
            res_q <= '{ST_OK, 16'd0, 16'd0};
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

### src/first_fit_allocator_coalescing.sv
// first-fit allocator: an allocate or free runs a cursor that walks held records
// then free segments through one compare/add unit, then applies the change and
// registers the result; a request refused after the held scan skips the free scan
// and the apply step, while init and no-op skip both scans
// one request at a time; s_axis_tready returns the cycle after the result is taken
// rst_ni clears both tables (no free segment until the first init), pool 1000/100
`timescale 1ns / 1ps

module first_fit_allocator_coalescing
  import ffa_pkg::*;
#(
  parameter int unsigned MaxHeld  = MaxHeldDefault,
  parameter int unsigned MaxFree  = MaxFreeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode[1:0], block_id[9:2], request_size[25:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[2:0], block_base[18:3], block_length[34:19]
);

  logic [15:0] pool_base, pool_length;
  logic        busy, done, out_v_q;
  result_t     res, out_q;

  ffa_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pool_base_o(pool_base), .pool_length_o(pool_length)
  );

  ffa_engine #(.MaxHeld(MaxHeld), .MaxFree(MaxFree)) u_engine (
    .clk_i, .rst_ni,
    .start_i(s_axis_tvalid & s_axis_tready),
    .op_i(opcode_e'(s_axis_tdata[1:0])),
    .id_i(s_axis_tdata[9:2]),
    .size_i(s_axis_tdata[25:10]),
    .pool_base_i(pool_base), .pool_length_i(pool_length),
    .busy_o(busy), .done_o(done), .res_o(res)
  );

  assign s_axis_tready = !busy && !out_v_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (done) begin
      out_v_q <= 1'b1;
      out_q   <= res;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_q.block_length, out_q.block_base, out_q.status};

endmodule
